@@ rtl/core/ordered_queue_engine_macros.svh @@
// Assertion macros for the ordered queue engine.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ORDERED_QUEUE_ENGINE_MACROS_SVH
`define ORDERED_QUEUE_ENGINE_MACROS_SVH

// property holds at every clock edge outside reset
`define OQE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define OQE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/oqe_pkg.sv @@
// Shared constants, types and helpers for the ordered queue engine.
// No dependencies.
package oqe_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 32;
  localparam int FIELD_W   = 32;
  localparam int ACT_W     = 3;
  localparam int POS_W     = 4;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_PUSH   = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_POP    = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_INSERT = ACT_W'(2);
  localparam logic [ACT_W-1:0] ACT_ERASE  = ACT_W'(3);
  localparam logic [ACT_W-1:0] ACT_GET    = ACT_W'(4);
  localparam logic [ACT_W-1:0] ACT_CLEAR  = ACT_W'(5);

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_INSERT,
    CELL_ERASE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    key_t     key;
  } cell_ctrl_t;

  function automatic key_t key_from_field(input logic [FIELD_W-1:0] f);
    key_t r;
    r = '0;
    for (int b = 0; b < KEY_WIDTH; b++) begin
      if (b < FIELD_W) r[b] = f[b];
    end
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] key_to_field(input key_t k);
    logic [FIELD_W-1:0] r;
    r = '0;
    for (int b = 0; b < FIELD_W; b++) begin
      if (b < KEY_WIDTH) r[b] = k[b];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/oqe_req_if.sv @@
// Request channel: action, key and position with valid/ready.
// Depends on oqe_pkg.
interface oqe_req_if;
  logic                             valid;
  logic                             ready;
  logic [oqe_pkg::ACT_W-1:0]        action;
  logic [oqe_pkg::FIELD_W-1:0]      key;
  logic [oqe_pkg::POS_W-1:0]        position;

  modport source(output valid, action, key, position, input ready);
  modport sink(input valid, action, key, position, output ready);
endinterface

@@ rtl/core/oqe_res_if.sv @@
// Result channel: ok, value and count with valid/ready.
// Depends on oqe_pkg.
interface oqe_res_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [oqe_pkg::FIELD_W-1:0] value;
  logic [oqe_pkg::CNT_W-1:0]   count;

  modport source(output valid, ok, value, count, input ready);
  modport sink(input valid, ok, value, count, output ready);
endinterface

@@ rtl/core/oqe_cfg_if.sv @@
// Configuration write channel: ordering_enabled with valid/ready.
// No dependencies.
interface oqe_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ rtl/core/oqe_cell.sv @@
// One queue slot: holds a key, compares against the broadcast key and
// passes the first-hit chain on to the next slot. Depends on oqe_pkg.
module oqe_cell (
  input  logic                clk_i,
  input  oqe_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic                at_tail_i,
  input  oqe_pkg::key_t       left_i,
  input  oqe_pkg::key_t       right_i,
  input  logic                seen_i,
  output oqe_pkg::key_t       key_o,
  output logic                seen_o
);

  oqe_pkg::key_t key_q, key_d;
  logic          hit;

  always_comb begin
    key_d  = key_q;
    hit    = 1'b0;
    seen_o = seen_i;
    unique case (ctrl_i.op)
      oqe_pkg::CELL_PUSH: begin
        if (at_tail_i) key_d = ctrl_i.key;
      end
      oqe_pkg::CELL_POP: begin
        key_d = right_i;
      end
      oqe_pkg::CELL_INSERT: begin
        hit    = !valid_i || (ctrl_i.key >= key_q);
        seen_o = seen_i || hit;
        if (seen_i) begin
          key_d = left_i;
        end else if (hit) begin
          key_d = ctrl_i.key;
        end
      end
      oqe_pkg::CELL_ERASE: begin
        hit    = valid_i && (key_q == ctrl_i.key);
        seen_o = seen_i || hit;
        if (seen_o) key_d = right_i;
      end
      default: begin
        key_d = key_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

@@ rtl/core/ordered_queue_engine.sv @@
// Ordered queue engine top level: a row of key cells plus the request
// sequencer. Depends on oqe_pkg, the channel interfaces, oqe_cell and
// ordered_queue_engine_macros.svh.
//
// Push, pop, insert, get and clear need no scan: the request is
// accepted, every cell updates in the same edge and the result is
// registered, so these requests can follow one per cycle while results
// are taken. Insert finds its slot through a first-hit chain across the
// cells and shifts the tail one place. With ordering enabled, erase
// scans: the cell row removes the first remaining match and closes the
// gap once per cycle until none is left, then registers the result; no
// request is taken during that scan. With ordering disabled, erase fails
// without a scan, like the other requests. The result register frees up
// in the cycle it is read, so a new request may be accepted in that
// cycle.
`include "ordered_queue_engine_macros.svh"

module ordered_queue_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  oqe_req_if.sink    req_i,
  oqe_cfg_if.sink    cfg_i,
  oqe_res_if.source  res_o
);

  typedef enum logic {ST_IDLE, ST_ERASE} state_e;

  state_e                      state_q, state_d;
  oqe_pkg::cnt_t               cnt_q, cnt_d;
  logic                        ord_q;
  logic                        found_q, found_d;
  oqe_pkg::key_t               erase_key_q, erase_key_d;
  logic                        res_valid_q, res_valid_d;
  logic                        res_ok_q, res_ok_d;
  logic [oqe_pkg::FIELD_W-1:0] res_value_q, res_value_d;
  oqe_pkg::cnt_t               res_cnt_q, res_cnt_d;

  oqe_pkg::cell_ctrl_t         ctrl;
  oqe_pkg::key_t               cell_key [oqe_pkg::DEPTH];
  logic                        seen [oqe_pkg::DEPTH+1];
  oqe_pkg::key_t               key_in;
  logic                        accept;
  logic                        not_full;
  logic                        get_hit;
  oqe_pkg::key_t               get_val;

  assign key_in      = oqe_pkg::key_from_field(req_i.key);
  assign req_i.ready = (state_q == ST_IDLE) && (!res_valid_q || res_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign not_full    = cnt_q < oqe_pkg::CNT_W'(oqe_pkg::DEPTH);
  assign cfg_i.ready = 1'b1;

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < oqe_pkg::DEPTH; g++) begin : g_cell
    localparam int L = (g == 0) ? 0 : g - 1;
    localparam int R = (g == oqe_pkg::DEPTH - 1) ? g : g + 1;
    oqe_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .valid_i   (oqe_pkg::CNT_W'(g) < cnt_q),
      .at_tail_i (oqe_pkg::CNT_W'(g) == cnt_q),
      .left_i    ((g == 0) ? ctrl.key : cell_key[L]),
      .right_i   (cell_key[R]),
      .seen_i    (seen[g]),
      .key_o     (cell_key[g]),
      .seen_o    (seen[g+1])
    );
  end

  always_comb begin
    get_hit = 1'b0;
    get_val = '0;
    for (int i = 0; i < oqe_pkg::DEPTH; i++) begin
      if ((int'(req_i.position) == i) && (oqe_pkg::CNT_W'(i) < cnt_q)) begin
        get_hit = 1'b1;
        get_val = cell_key[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    erase_key_d = erase_key_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_ok_d    = res_ok_q;
    res_value_d = res_value_q;
    res_cnt_d   = res_cnt_q;
    ctrl.op     = oqe_pkg::CELL_HOLD;
    ctrl.key    = key_in;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          res_ok_d    = 1'b0;
          res_value_d = '0;
          unique case (req_i.action)
            oqe_pkg::ACT_PUSH: begin
              if (not_full) begin
                ctrl.op  = oqe_pkg::CELL_PUSH;
                cnt_d    = cnt_q + 1'b1;
                res_ok_d = 1'b1;
              end
            end
            oqe_pkg::ACT_POP: begin
              if (cnt_q != '0) begin
                ctrl.op     = oqe_pkg::CELL_POP;
                cnt_d       = cnt_q - 1'b1;
                res_ok_d    = 1'b1;
                res_value_d = oqe_pkg::key_to_field(cell_key[0]);
              end
            end
            oqe_pkg::ACT_INSERT: begin
              if (ord_q && not_full) begin
                ctrl.op  = oqe_pkg::CELL_INSERT;
                cnt_d    = cnt_q + 1'b1;
                res_ok_d = 1'b1;
              end
            end
            oqe_pkg::ACT_ERASE: begin
              if (ord_q) begin
                res_valid_d = 1'b0;
                state_d     = ST_ERASE;
                found_d     = 1'b0;
                erase_key_d = key_in;
              end
            end
            oqe_pkg::ACT_GET: begin
              res_ok_d    = get_hit;
              res_value_d = oqe_pkg::key_to_field(get_val);
            end
            oqe_pkg::ACT_CLEAR: begin
              cnt_d    = '0;
              res_ok_d = 1'b1;
            end
            default: begin
              res_ok_d = 1'b0;
            end
          endcase
          res_cnt_d = cnt_d;
        end
      end
      ST_ERASE: begin
        ctrl.op  = oqe_pkg::CELL_ERASE;
        ctrl.key = erase_key_q;
        if (seen[oqe_pkg::DEPTH]) begin
          cnt_d   = cnt_q - 1'b1;
          found_d = 1'b1;
        end else begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          res_ok_d    = found_q;
          res_value_d = '0;
          res_cnt_d   = cnt_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ord_q       <= 1'b0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_ok_q    <= 1'b0;
      res_value_q <= '0;
      res_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      res_valid_q <= res_valid_d;
      res_ok_q    <= res_ok_d;
      res_value_q <= res_value_d;
      res_cnt_q   <= res_cnt_d;
      if (cfg_i.valid) ord_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    erase_key_q <= erase_key_d;
  end

  assign res_o.valid = res_valid_q;
  assign res_o.ok    = res_ok_q;
  assign res_o.value = res_value_q;
  assign res_o.count = res_cnt_q;

  `OQE_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= oqe_pkg::CNT_W'(oqe_pkg::DEPTH),
    "count above depth")
  `OQE_ASSERT_ALWAYS(a_no_req_in_scan, (state_q != ST_ERASE) || !req_i.ready,
    "request during erase")
  `OQE_ASSERT_NEXT(a_push_count,
    accept && (req_i.action == oqe_pkg::ACT_PUSH) && not_full,
    (cnt_q == $past(cnt_q) + 1'b1) && res_valid_q && res_ok_q, "push count")
  `OQE_ASSERT_NEXT(a_scan_shrinks, (state_q == ST_ERASE) && seen[oqe_pkg::DEPTH],
    (cnt_q == $past(cnt_q) - 1'b1) && found_q, "erase step")

endmodule
